/* sv/rssd_pkg.sv */
// Shared types and constants for the rest-state sleep detector.
// No dependencies; imported by every module of the block.
package rssd_pkg;

  // Field widths
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned VEL_W   = 16;
  localparam int unsigned DT_W    = 16;
  localparam int unsigned TIMER_W = 24;
  localparam int unsigned SQ_W    = 32;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned REG_IDX_W = 2;

  localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_SPEED_SQ_LIMIT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SPIN_SQ_LIMIT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HOLD_TIME      = 2'd2;

  localparam logic [TIMER_W-1:0] HOLD_TIME_RESET = 24'd500000;

  // Current configuration as seen by the datapath
  typedef struct packed {
    logic [SQ_W-1:0]    speed_sq_limit;
    logic [SQ_W-1:0]    spin_sq_limit;
    logic [TIMER_W-1:0] hold_time;
  } cfg_t;

endpackage

/* sv/rssd_regs.sv */
// Configuration register file for the sleep detector.
// Depends on rssd_pkg for register indexes and cfg_t.
module rssd_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [rssd_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [rssd_pkg::CFG_W-1:0]     cfg_data,
  output rssd_pkg::cfg_t                 cfg
);
  import rssd_pkg::*;

  // Plain write port; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_sq_limit <= '0;
      cfg.spin_sq_limit  <= '0;
      cfg.hold_time      <= HOLD_TIME_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SPEED_SQ_LIMIT: cfg.speed_sq_limit <= cfg_data[SQ_W-1:0];
        REG_SPIN_SQ_LIMIT:  cfg.spin_sq_limit  <= cfg_data[SQ_W-1:0];
        REG_HOLD_TIME:      cfg.hold_time      <= cfg_data[TIMER_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* sv/rssd_motion.sv */
// Velocity path: input registers, six squares, then sums and limit compares.
// Depends on rssd_pkg for widths and cfg_t.
module rssd_motion (
  input  logic                             clk,
  input  logic                             adv,
  input  logic signed [rssd_pkg::VEL_W-1:0] lin_vel_x,
  input  logic signed [rssd_pkg::VEL_W-1:0] lin_vel_y,
  input  logic signed [rssd_pkg::VEL_W-1:0] lin_vel_z,
  input  logic signed [rssd_pkg::VEL_W-1:0] ang_vel_x,
  input  logic signed [rssd_pkg::VEL_W-1:0] ang_vel_y,
  input  logic signed [rssd_pkg::VEL_W-1:0] ang_vel_z,
  input  rssd_pkg::cfg_t                   cfg,
  output logic                             quiet
);
  import rssd_pkg::*;

  localparam int unsigned PROD_W = 2 * VEL_W;
  localparam int unsigned SQR_W  = PROD_W - 1;  // a square never exceeds 2^30

  logic signed [VEL_W-1:0] lin1 [3];
  logic signed [VEL_W-1:0] ang1 [3];
  logic [SQR_W-1:0]        lin_sq [3];
  logic [SQR_W-1:0]        ang_sq [3];
  logic signed [PROD_W-1:0] lin_p [3];
  logic signed [PROD_W-1:0] ang_p [3];
  logic [SQ_W-1:0]         lin_sum;
  logic [SQ_W-1:0]         ang_sum;

  // Stage 1: capture velocities
  always_ff @(posedge clk) begin
    if (adv) begin
      lin1[0] <= lin_vel_x;
      lin1[1] <= lin_vel_y;
      lin1[2] <= lin_vel_z;
      ang1[0] <= ang_vel_x;
      ang1[1] <= ang_vel_y;
      ang1[2] <= ang_vel_z;
    end
  end

  // Six independent 16x16 squares
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lin_p[i] = lin1[i] * lin1[i];
      ang_p[i] = ang1[i] * ang1[i];
    end
  end

  // Stage 2: registered squares
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        lin_sq[i] <= lin_p[i][SQR_W-1:0];
        ang_sq[i] <= ang_p[i][SQR_W-1:0];
      end
    end
  end

  // Sum of three squares fits 32 bits; strict compare against limits
  assign lin_sum = SQ_W'(lin_sq[0]) + SQ_W'(lin_sq[1]) + SQ_W'(lin_sq[2]);
  assign ang_sum = SQ_W'(ang_sq[0]) + SQ_W'(ang_sq[1]) + SQ_W'(ang_sq[2]);
  assign quiet   = (lin_sum < cfg.speed_sq_limit) && (ang_sum < cfg.spin_sq_limit);

endmodule

/* sv/rssd_timer_ram.sv */
// Per-body quiet timer memory with a clearing sweep after reset.
// Depends on rssd_pkg for the timer width.
module rssd_timer_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  output logic                             busy,
  input  logic                             we,
  input  logic [AW-1:0]                    waddr,
  input  logic [rssd_pkg::TIMER_W-1:0]     wdata,
  input  logic                             re,
  input  logic [AW-1:0]                    raddr,
  output logic [rssd_pkg::TIMER_W-1:0]     rdata
);
  import rssd_pkg::*;

  logic [TIMER_W-1:0] mem [DEPTH];
  logic [AW-1:0]      clr_addr;

  // Clearing sweep: one entry per cycle starting at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Single write port, shared by the sweep and timer updates
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/rest_state_sleep_detector.sv */
// Pipeline: an accepted item passes three register stages (stage 1, stage 2, output register);
// a stall holds them all. Throughput: one item per cycle while no stall or clearing sweep
// holds input; the timer memory is read in stage 1 and written in stage 2, one port each.
// Reset: synchronous; a clearing sweep zeroes the timers and holds in_stall high meanwhile.
// Configuration writes are taken during the sweep.
module rest_state_sleep_detector #(
  parameter int unsigned BODIES = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [rssd_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [rssd_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rssd_pkg::IDX_W-1:0]        body_num,
  input  logic signed [rssd_pkg::VEL_W-1:0] lin_vel_x,
  input  logic signed [rssd_pkg::VEL_W-1:0] lin_vel_y,
  input  logic signed [rssd_pkg::VEL_W-1:0] lin_vel_z,
  input  logic signed [rssd_pkg::VEL_W-1:0] ang_vel_x,
  input  logic signed [rssd_pkg::VEL_W-1:0] ang_vel_y,
  input  logic signed [rssd_pkg::VEL_W-1:0] ang_vel_z,
  input  logic [rssd_pkg::DT_W-1:0]         step_time,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rssd_pkg::IDX_W-1:0]        body_index,
  output logic                              go_to_sleep,
  output logic                              is_quiet
);
  import rssd_pkg::*;

  localparam int unsigned AW = $clog2(BODIES);

  cfg_t               cfg;
  logic               adv;
  logic               busy;
  logic               quiet;

  // Stage 1 and stage 2 control and payload
  logic               v1, v2;
  logic [IDX_W-1:0]   idx1, idx2;
  logic [DT_W-1:0]    dt1, dt2;
  logic               inr1, inr2;

  // Last timer write, forwarded past the read that missed it
  logic               fw_valid;
  logic [AW-1:0]      fw_addr;
  logic [TIMER_W-1:0] fw_data;

  logic [AW-1:0]      addr2;
  logic [TIMER_W-1:0] rdata;
  logic [TIMER_W-1:0] old_timer;
  logic [TIMER_W:0]   timer_sum;
  logic [TIMER_W-1:0] timer_sat;
  logic [TIMER_W-1:0] timer_next;
  logic               wr_en;
  logic               sleep;

  rssd_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rssd_motion u_motion (
    .clk       (clk),
    .adv       (adv),
    .lin_vel_x (lin_vel_x),
    .lin_vel_y (lin_vel_y),
    .lin_vel_z (lin_vel_z),
    .ang_vel_x (ang_vel_x),
    .ang_vel_y (ang_vel_y),
    .ang_vel_z (ang_vel_z),
    .cfg       (cfg),
    .quiet     (quiet)
  );

  rssd_timer_ram #(
    .DEPTH (BODIES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .rst   (rst),
    .busy  (busy),
    .we    (wr_en),
    .waddr (addr2),
    .wdata (timer_next),
    .re    (adv),
    .raddr (AW'(idx1)),
    .rdata (rdata)
  );

  // Whole pipeline moves when the output register is free or being taken
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv || busy;

  // Stage 1: accept an item
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx1 <= body_num;
      dt1  <= step_time;
      inr1 <= 32'(body_num) < 32'(BODIES);
    end
  end

  // Stage 2: timer read data arrives here
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idx2 <= idx1;
      dt2  <= dt1;
      inr2 <= inr1;
    end
  end

  // Timer update with forwarding of the write made at the previous step
  assign addr2      = AW'(idx2);
  assign old_timer  = (fw_valid && fw_addr == addr2) ? fw_data : rdata;
  assign timer_sum  = {1'b0, old_timer} + (TIMER_W + 1)'(dt2);
  assign timer_sat  = timer_sum[TIMER_W] ? TIMER_MAX : timer_sum[TIMER_W-1:0];
  assign timer_next = quiet ? timer_sat : '0;
  assign wr_en      = adv && v2 && inr2;
  assign sleep      = quiet && inr2 && (timer_sat >= cfg.hold_time);

  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid <= 1'b0;
    end else if (adv) begin
      fw_valid <= v2 && inr2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fw_addr <= addr2;
      fw_data <= timer_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      body_index  <= idx2;
      go_to_sleep <= sleep;
      is_quiet    <= quiet;
    end
  end

endmodule

/* sv/rssd_checker.sv */
// Port-level checks for the sleep detector, bound to the top level.
// Depends on rssd_pkg for field widths.
module rssd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [rssd_pkg::IDX_W-1:0] body_index,
  input logic                       go_to_sleep,
  input logic                       is_quiet
);
  import rssd_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(body_index)
      && $stable(go_to_sleep) && $stable(is_quiet))
    else $error("stalled result changed");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Timer clearing sweep blocks input right after reset
  a_reset_sweep: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input accepted during clearing sweep");

  // Sleep is only requested for a quiet body
  a_sleep_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !go_to_sleep || is_quiet)
    else $error("sleep without quiet");

endmodule

bind rest_state_sleep_detector rssd_checker u_rssd_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .body_index  (body_index),
  .go_to_sleep (go_to_sleep),
  .is_quiet    (is_quiet)
);

/* test/tb_rest_state_sleep_detector.sv */
// Self-checking testbench for rest_state_sleep_detector.
// Depends on rssd_pkg and the RTL of the block; predicts each verdict in place
// and checks every result item in order under varied idling and register settings.
`timescale 1ns / 100ps

module tb_rest_state_sleep_detector;
  import rssd_pkg::*;

  localparam int unsigned BODY_COUNT  = 1024;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [SQ_W-1:0] SQ_FULL = 32'd3221225472;

  typedef struct packed {
    logic [IDX_W-1:0]        piece;
    logic signed [VEL_W-1:0] lx;
    logic signed [VEL_W-1:0] ly;
    logic signed [VEL_W-1:0] lz;
    logic signed [VEL_W-1:0] ax;
    logic signed [VEL_W-1:0] ay;
    logic signed [VEL_W-1:0] az;
    logic [DT_W-1:0]         dt;
  } sample_t;

  typedef struct packed {
    logic [IDX_W-1:0] body;
    logic             sleep;
    logic             quiet;
  } verdict_t;

  // DUT ports
  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [REG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_W-1:0]         cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [IDX_W-1:0]         body_num = '0;
  logic signed [VEL_W-1:0]  lin_vel_x = '0;
  logic signed [VEL_W-1:0]  lin_vel_y = '0;
  logic signed [VEL_W-1:0]  lin_vel_z = '0;
  logic signed [VEL_W-1:0]  ang_vel_x = '0;
  logic signed [VEL_W-1:0]  ang_vel_y = '0;
  logic signed [VEL_W-1:0]  ang_vel_z = '0;
  logic [DT_W-1:0]          step_time = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [IDX_W-1:0]         body_index;
  logic                     go_to_sleep;
  logic                     is_quiet;

  // Predictor state: register copies and per-body quiet timers
  logic [SQ_W-1:0]    speed_lim;
  logic [SQ_W-1:0]    spin_lim;
  logic [TIMER_W-1:0] hold_us;
  logic [TIMER_W-1:0] quiet_us [BODY_COUNT];

  sample_t     pending_samples[$];
  verdict_t    expected_verdicts[$];
  int unsigned samples_queued = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned vel_amp = 256;
  bit          sample_taken = 1'b0;

  rest_state_sleep_detector dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .body_num(body_num),
    .lin_vel_x(lin_vel_x), .lin_vel_y(lin_vel_y), .lin_vel_z(lin_vel_z),
    .ang_vel_x(ang_vel_x), .ang_vel_y(ang_vel_y), .ang_vel_z(ang_vel_z),
    .step_time(step_time),
    .out_valid(out_valid), .out_stall(out_stall),
    .body_index(body_index), .go_to_sleep(go_to_sleep), .is_quiet(is_quiet)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Expected verdict for one sample; advances the body's quiet timer
  function automatic verdict_t predict_rest_verdict(sample_t s);
    longint             lin_sq;
    longint             ang_sq;
    logic [TIMER_W:0]   grown;
    verdict_t           v;
    lin_sq = longint'($signed(s.lx)) * longint'($signed(s.lx))
           + longint'($signed(s.ly)) * longint'($signed(s.ly))
           + longint'($signed(s.lz)) * longint'($signed(s.lz));
    ang_sq = longint'($signed(s.ax)) * longint'($signed(s.ax))
           + longint'($signed(s.ay)) * longint'($signed(s.ay))
           + longint'($signed(s.az)) * longint'($signed(s.az));
    v.body  = s.piece;
    v.quiet = (lin_sq < longint'(speed_lim)) && (ang_sq < longint'(spin_lim));
    v.sleep = 1'b0;
    if (v.quiet) begin
      grown = quiet_us[s.piece] + s.dt;
      if (grown > TIMER_MAX) grown = TIMER_MAX;
      quiet_us[s.piece] = grown[TIMER_W-1:0];
      v.sleep = (grown[TIMER_W-1:0] >= hold_us);
    end else begin
      quiet_us[s.piece] = '0;
    end
    return v;
  endfunction

  function automatic sample_t mk(int idx, int lx, int ly, int lz,
                                 int ax, int ay, int az, int dt);
    sample_t s;
    s.piece = IDX_W'(idx);
    s.lx = VEL_W'(lx);
    s.ly = VEL_W'(ly);
    s.lz = VEL_W'(lz);
    s.ax = VEL_W'(ax);
    s.ay = VEL_W'(ay);
    s.az = VEL_W'(az);
    s.dt = DT_W'(dt);
    return s;
  endfunction

  // Calm component: small magnitude near the limits; otherwise any 16-bit value
  function automatic logic signed [VEL_W-1:0] pick_vel(bit calm, int unsigned span);
    int m;
    if (!calm) return VEL_W'($urandom);
    m = int'($urandom_range(span));
    if ($urandom_range(1)) m = -m;
    return VEL_W'(m);
  endfunction

  // Mostly a small pool of bodies with calm motion, so timers build up
  function automatic sample_t random_sample(int unsigned pool, int unsigned calm_pct,
                                            int unsigned dt_lo);
    sample_t     s;
    int unsigned span;
    bit          lin_calm;
    bit          ang_calm;
    span = vel_amp * 3 / 4;
    lin_calm = ($urandom_range(99) < calm_pct);
    ang_calm = ($urandom_range(99) < calm_pct);
    s.piece = ($urandom_range(99) < calm_pct) ? IDX_W'($urandom_range(pool - 1))
                                              : IDX_W'($urandom);
    s.lx = pick_vel(lin_calm, span);
    s.ly = pick_vel(lin_calm, span);
    s.lz = pick_vel(lin_calm, span);
    s.ax = pick_vel(ang_calm, span);
    s.ay = pick_vel(ang_calm, span);
    s.az = pick_vel(ang_calm, span);
    s.dt = DT_W'($urandom_range(65535, dt_lo));
    return s;
  endfunction

  task automatic push_sample(sample_t s);
    pending_samples.insert(pending_samples.size(), s);
    samples_queued++;
  endtask

  // One register write; the caller lowers cfg_write after its last write
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_SPEED_SQ_LIMIT: speed_lim = data;
      REG_SPIN_SQ_LIMIT:  spin_lim  = data;
      REG_HOLD_TIME:      hold_us   = data[TIMER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [SQ_W-1:0] speed, logic [SQ_W-1:0] spin,
                            logic [CFG_W-1:0] hold_word);
    write_reg(REG_SPEED_SQ_LIMIT, speed);
    write_reg(REG_SPIN_SQ_LIMIT, spin);
    write_reg(REG_HOLD_TIME, hold_word);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Block until every queued item has produced its result, then let the pipe empty
  task automatic wait_drained();
    while (results_seen < samples_queued) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Sender: next item at the falling edge once the previous one was taken
  always @(negedge clk) begin : drive_proc
    sample_t nxt;
    if (!rst) begin
      if (!in_valid || sample_taken) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_samples.pop_front();
          in_valid    <= 1'b1;
          body_num    <= nxt.piece;
          lin_vel_x   <= nxt.lx;
          lin_vel_y   <= nxt.ly;
          lin_vel_z   <= nxt.lz;
          ang_vel_x   <= nxt.ax;
          ang_vel_y   <= nxt.ay;
          ang_vel_z   <= nxt.az;
          step_time   <= nxt.dt;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Predict on each accepted item, check each accepted result
  always @(posedge clk) begin : check_proc
    verdict_t want;
    sample_taken = (in_valid === 1'b1) && (in_stall === 1'b0);
    if (sample_taken)
      expected_verdicts.insert(expected_verdicts.size(),
        predict_rest_verdict(mk(body_num, lin_vel_x, lin_vel_y,
        lin_vel_z, ang_vel_x, ang_vel_y, ang_vel_z, step_time)));
    if (!rst && out_valid !== 1'b0 && out_stall === 1'b0) begin
      results_seen++;
      if (expected_verdicts.size() == 0) begin
        $display("%0t: unexpected result item, expected none, got body %0d", $time,
                 body_index);
        mismatches++;
      end else begin
        want = expected_verdicts.pop_front();
        if (out_valid !== 1'b1) begin
          $display("%0t: out_valid expected 1 got %b", $time, out_valid);
          mismatches++;
        end
        if (body_index !== want.body) begin
          $display("%0t: body_index expected %0d got %0d", $time, want.body, body_index);
          mismatches++;
        end
        if (go_to_sleep !== want.sleep) begin
          $display("%0t: go_to_sleep (body %0d) expected %b got %b", $time, want.body,
                   want.sleep, go_to_sleep);
          mismatches++;
        end
        if (is_quiet !== want.quiet) begin
          $display("%0t: is_quiet (body %0d) expected %b got %b", $time, want.body,
                   want.quiet, is_quiet);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned send_mode [4];
    int unsigned recv_mode [4];
    int unsigned hold_val;
    send_mode = '{0, 78, 0, 19};
    recv_mode = '{0, 0, 78, 19};
    speed_lim = '0;
    spin_lim  = '0;
    hold_us   = HOLD_TIME_RESET;
    foreach (quiet_us[i]) quiet_us[i] = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: zero limits, so nothing is ever quiet
    push_sample(mk(0, 0, 0, 0, 0, 0, 0, 0));
    push_sample(mk(1023, 32767, 32767, 32767, 32767, 32767, 32767, 65535));
    push_sample(mk(512, -32768, -32768, -32768, -32768, -32768, -32768, 65535));
    wait_drained();

    // Zero hold time and a limit of exactly 256^2; unknown register write ignored
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    set_config(32'd65536, 32'd65536, 32'd0);
    push_sample(mk(5, 255, 0, 0, 0, 0, 0, 0));
    push_sample(mk(5, 256, 0, 0, 0, 0, 0, 10));
    push_sample(mk(5, 0, 0, 0, 0, -256, 0, 10));
    push_sample(mk(6, -255, 0, 0, 0, 0, 255, 100));
    push_sample(mk(6, 0, 0, 0, -147, 147, 147, 7));
    wait_drained();

    // Widest limits: only the all-negative-extreme vectors (linear or angular) fail; hold boundary
    set_config(SQ_FULL, SQ_FULL, 32'd131070);
    push_sample(mk(7, -32768, -32768, -32768, 0, 0, 0, 65535));
    push_sample(mk(7, -32768, -32768, 32767, 32767, 32767, 32767, 65535));
    push_sample(mk(7, -32768, -32768, 32767, 32767, 32767, 32767, 65534));
    push_sample(mk(7, 1, -1, 0, 0, 0, 0, 1));
    push_sample(mk(7, 0, 0, 0, 0, 0, 0, 0));
    push_sample(mk(7, 0, 0, 0, -32768, -32768, -32768, 65535));
    push_sample(mk(7, 0, 0, 0, 0, 0, 0, 65535));
    wait_drained();

    // Random phases, one per idling pattern, each with fresh settings
    for (int ph = 0; ph < 4; ph++) begin
      vel_amp = 1 << $urandom_range(12, 4);
      hold_val = (ph == 1) ? 0 : $urandom_range(300000, 0);
      set_config($urandom_range(3 * vel_amp * vel_amp, vel_amp * vel_amp),
                 $urandom_range(3 * vel_amp * vel_amp, vel_amp * vel_amp),
                 {8'($urandom), TIMER_W'(hold_val)});
      send_idle_pct  = send_mode[ph];
      recv_stall_pct = recv_mode[ph];
      repeat (175) push_sample(random_sample(4, 90, 0));
      wait_drained();
    end

    // Long quiet runs on two bodies to drive their timers into saturation
    vel_amp = 256;
    set_config(SQ_FULL, SQ_FULL, 32'hFFFF_FFFF);
    repeat (600) push_sample(random_sample(2, 100, 60000));
    wait_drained();

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/rssd_pkg.sv
sv/rssd_regs.sv
sv/rssd_motion.sv
sv/rssd_timer_ram.sv
sv/rest_state_sleep_detector.sv
sv/rssd_checker.sv
test/tb_rest_state_sleep_detector.sv
